>>> rtl/dbl_pkg.sv
package dbl_pkg;

   // Fixed field widths.
   localparam int DEPTH_BITS = 24;
   localparam int COEFF_BITS = 40;
   localparam int WIDE_BITS  = 64;
   localparam int QUO_BITS   = 16;
   localparam int FRAC_W     = QUO_BITS + 1;
   localparam int GRAY_BITS  = 8;
   localparam int TEXEL_BITS = 32;
   localparam int CSR_IDX_W  = 2;

   // Partial product split of the 40-bit coefficient for the orthographic product.
   localparam int PP_SPLIT = 20;
   localparam int PP_W     = PP_SPLIT + DEPTH_BITS;

   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
   localparam logic [FRAC_W-1:0]     FRAC_ONE  = FRAC_W'(1) << QUO_BITS;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_PERSPECTIVE_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_COEFF      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_COEFF     = 2'd2;

   // How the result of one texel is formed.
   typedef enum logic [1:0] {
      CODE_DIVIDE,
      CODE_ZERO,
      CODE_ONE_CLAMP,
      CODE_ONE_EXACT
   } dbl_code_type;

   typedef struct packed {
      logic                  perspective_mode;
      logic [COEFF_BITS-1:0] scale_coeff;
      logic [COEFF_BITS-1:0] offset_coeff;
   } dbl_cfg_type;

   // Data handed from one divider cell to the next.
   typedef struct packed {
      logic [WIDE_BITS-1:0] rem;
      logic [WIDE_BITS-1:0] div;
      logic [QUO_BITS-1:0]  quo;
      dbl_code_type         code;
   } dbl_cell_type;

endpackage

>>> rtl/dbl_req_if.sv
interface dbl_req_if;
   import dbl_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [TEXEL_BITS-1:0] texel_word;

   modport source (output valid, output texel_word, input ready);
   modport sink   (input valid, input texel_word, output ready);
endinterface

>>> rtl/dbl_rsp_if.sv
interface dbl_rsp_if;
   import dbl_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [FRAC_W-1:0]    depth_fraction;
   logic [GRAY_BITS-1:0] gray_level;
   logic                 was_clamped;

   modport source (output valid, output depth_fraction, output gray_level,
                   output was_clamped, input ready);
   modport sink   (input valid, input depth_fraction, input gray_level,
                   input was_clamped, output ready);
endinterface

>>> rtl/dbl_prep.sv
module dbl_prep #(
   parameter int FRAC_BITS = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  dbl_pkg::dbl_cfg_type               cfg,
   input  logic                               up_valid,
   output logic                               up_ready,
   input  logic [dbl_pkg::DEPTH_BITS-1:0]     up_raw,
   output logic                               dn_valid,
   input  logic                               dn_ready,
   output dbl_pkg::dbl_cell_type              dn_data
);
   import dbl_pkg::*;

   // Stage 1: products and the scaled perspective terms.
   logic                  s1_valid_ff;
   logic                  s1_mode_ff;
   logic [DEPTH_BITS-1:0] s1_raw_ff;
   logic [PP_W-1:0]       s1_pp_lo_ff, s1_pp_lo_in;
   logic [PP_W-1:0]       s1_pp_hi_ff, s1_pp_hi_in;
   logic [WIDE_BITS-1:0]  s1_dm_ff, s1_dm_in;
   logic [WIDE_BITS-1:0]  s1_nm_ff, s1_nm_in;
   logic                  s1_ready;

   // Stage 2: numerator, divisor and the divisor sign checks.
   logic                  s2_valid_ff;
   logic [WIDE_BITS-1:0]  s2_num_ff, s2_num_in;
   logic [WIDE_BITS-1:0]  s2_div_ff, s2_div_in;
   dbl_code_type          s2_code_ff, s2_code_in;
   logic                  s2_ready;
   logic [WIDE_BITS-1:0]  rf;
   logic [WIDE_BITS:0]    diff;
   logic [WIDE_BITS-1:0]  ortho_num;
   logic [WIDE_BITS-1:0]  ortho_div;

   // Stage 3: saturation check, feeds the first divider cell.
   logic                  s3_valid_ff;
   dbl_cell_type          s3_data_ff, s3_data_in;
   logic                  s3_ready;

   assign s3_ready = !s3_valid_ff || dn_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign up_ready = s1_ready;

   // Multiplying by 2^24-1 is a shift and a subtract.
   always_comb begin
      s1_pp_lo_in = PP_W'(cfg.scale_coeff[PP_SPLIT-1:0]) * PP_W'(up_raw);
      s1_pp_hi_in = PP_W'(cfg.scale_coeff[COEFF_BITS-1:PP_SPLIT]) * PP_W'(up_raw);
      s1_dm_in    = {cfg.offset_coeff, {DEPTH_BITS{1'b0}}} - WIDE_BITS'(cfg.offset_coeff);
      s1_nm_in    = {cfg.scale_coeff, {DEPTH_BITS{1'b0}}} - WIDE_BITS'(cfg.scale_coeff);
   end

   // Perspective divisor is dm - raw*2^F; orthographic divisor is M*2^F.
   always_comb begin
      rf        = WIDE_BITS'(s1_raw_ff) << FRAC_BITS;
      diff      = {1'b0, s1_dm_ff} - {1'b0, rf};
      ortho_num = {s1_pp_hi_ff, {PP_SPLIT{1'b0}}} + WIDE_BITS'(s1_pp_lo_ff);
      ortho_div = WIDE_BITS'(DEPTH_MAX) << FRAC_BITS;
      if (s1_mode_ff) begin
         s2_num_in = s1_nm_ff;
         s2_div_in = diff[WIDE_BITS-1:0];
         priority if (diff[WIDE_BITS]) begin
            s2_code_in = CODE_ZERO;
         end else if (diff == '0) begin
            s2_code_in = CODE_ONE_CLAMP;
         end else begin
            s2_code_in = CODE_DIVIDE;
         end
      end else begin
         s2_num_in  = ortho_num;
         s2_div_in  = ortho_div;
         s2_code_in = CODE_DIVIDE;
      end
   end

   // A quotient of one or more saturates; only above one counts as clamped.
   always_comb begin
      s3_data_in.rem  = s2_num_ff;
      s3_data_in.div  = s2_div_ff;
      s3_data_in.quo  = '0;
      s3_data_in.code = s2_code_ff;
      if (s2_code_ff == CODE_DIVIDE) begin
         priority if (s2_num_ff > s2_div_ff) begin
            s3_data_in.code = CODE_ONE_CLAMP;
         end else if (s2_num_ff == s2_div_ff) begin
            s3_data_in.code = CODE_ONE_EXACT;
         end else begin
            s3_data_in.code = CODE_DIVIDE;
         end
      end
   end

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= up_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_mode_ff  <= cfg.perspective_mode;
         s1_raw_ff   <= up_raw;
         s1_pp_lo_ff <= s1_pp_lo_in;
         s1_pp_hi_ff <= s1_pp_hi_in;
         s1_dm_ff    <= s1_dm_in;
         s1_nm_ff    <= s1_nm_in;
      end
      if (s2_ready) begin
         s2_num_ff  <= s2_num_in;
         s2_div_ff  <= s2_div_in;
         s2_code_ff <= s2_code_in;
      end
      if (s3_ready) begin
         s3_data_ff <= s3_data_in;
      end
   end

   assign dn_valid = s3_valid_ff;
   assign dn_data  = s3_data_ff;

endmodule

>>> rtl/dbl_div_cell.sv
module dbl_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  dbl_pkg::dbl_cell_type up_data,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output dbl_pkg::dbl_cell_type dn_data
);
   import dbl_pkg::*;

   logic               valid_ff;
   dbl_cell_type       data_ff, data_in;
   logic [WIDE_BITS:0] rem_sh;
   logic [WIDE_BITS:0] rem_sub;

   assign up_ready = !valid_ff || dn_ready;

   // One restoring division step: shift, trial subtract, keep if not negative.
   always_comb begin
      rem_sh  = {up_data.rem, 1'b0};
      rem_sub = rem_sh - {1'b0, up_data.div};
      data_in = up_data;
      if (!rem_sub[WIDE_BITS]) begin
         data_in.rem = rem_sub[WIDE_BITS-1:0];
         data_in.quo = {up_data.quo[QUO_BITS-2:0], 1'b1};
      end else begin
         data_in.rem = rem_sh[WIDE_BITS-1:0];
         data_in.quo = {up_data.quo[QUO_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

>>> rtl/dbl_out.sv
module dbl_out (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              up_valid,
   output logic                              up_ready,
   input  dbl_pkg::dbl_cell_type             up_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [dbl_pkg::FRAC_W-1:0]        depth_fraction,
   output logic [dbl_pkg::GRAY_BITS-1:0]     gray_level,
   output logic                              was_clamped
);
   import dbl_pkg::*;

   localparam int PROD_W = FRAC_W + GRAY_BITS;

   logic                 valid_ff;
   logic [FRAC_W-1:0]    frac_ff, frac_in;
   logic [GRAY_BITS-1:0] gray_ff, gray_in;
   logic                 clamp_ff, clamp_in;
   logic [PROD_W-1:0]    prod;

   assign up_ready = !valid_ff || rsp_ready;

   // Final fraction from the code, and the gray level as frac*255 >> 16.
   always_comb begin
      unique case (up_data.code)
         CODE_DIVIDE: begin
            frac_in  = {1'b0, up_data.quo};
            clamp_in = 1'b0;
         end
         CODE_ZERO: begin
            frac_in  = '0;
            clamp_in = 1'b1;
         end
         CODE_ONE_CLAMP: begin
            frac_in  = FRAC_ONE;
            clamp_in = 1'b1;
         end
         default: begin
            frac_in  = FRAC_ONE;
            clamp_in = 1'b0;
         end
      endcase
      prod    = {frac_in, {GRAY_BITS{1'b0}}} - PROD_W'(frac_in);
      gray_in = prod[QUO_BITS +: GRAY_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         frac_ff  <= frac_in;
         gray_ff  <= gray_in;
         clamp_ff <= clamp_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign depth_fraction = frac_ff;
   assign gray_level     = gray_ff;
   assign was_clamped    = clamp_ff;

endmodule

>>> rtl/depth_buffer_linearizer_top.sv
// Depth buffer linearizer: one 32-bit depth-stencil texel in, one linear depth out.
// The req channel carries texel_word; bits 23..0 are the depth, the stencil byte is
// dropped. The rsp channel returns depth_fraction (65536 means 1.0), an 8-bit
// gray_level and was_clamped. Each channel moves one item per transfer when valid
// and ready are both high.
// The csr port writes perspective_mode, scale_coeff and offset_coeff; write them
// only while no texel is in flight.
// A req transfer passes three preparation stages, sixteen divider cells that
// each produce one quotient bit, and the output register before rsp valid.
// Throughput is one texel per cycle while rsp is not stalled.
// Every stage has its own valid flag and accepts new data whenever it is empty
// or its successor moves, so bubbles close up while rsp is stalled; the input
// keeps taking texels until all 20 stages hold data.
// Reset (synchronous) empties the pipeline and restores perspective mode with
// both coefficients at 1.0.
module depth_buffer_linearizer_top #(
   parameter int FRAC_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   dbl_req_if.sink                           req,
   dbl_rsp_if.source                         rsp,
   input  logic                              csr_wr_en,
   input  logic [dbl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dbl_pkg::COEFF_BITS-1:0]    csr_wdata
);
   import dbl_pkg::*;

   dbl_cfg_type  cfg_ff;
   logic         cell_valid [QUO_BITS+1];
   logic         cell_ready [QUO_BITS+1];
   dbl_cell_type cell_data  [QUO_BITS+1];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.perspective_mode <= 1'b1;
         cfg_ff.scale_coeff      <= COEFF_BITS'(1) << FRAC_BITS;
         cfg_ff.offset_coeff     <= COEFF_BITS'(1) << FRAC_BITS;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_PERSPECTIVE_MODE: cfg_ff.perspective_mode <= csr_wdata[0];
            REG_SCALE_COEFF:      cfg_ff.scale_coeff      <= csr_wdata;
            REG_OFFSET_COEFF:     cfg_ff.offset_coeff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Numerator, divisor and special cases.
   dbl_prep #(
      .FRAC_BITS (FRAC_BITS)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .up_valid (req.valid),
      .up_ready (req.ready),
      .up_raw   (req.texel_word[DEPTH_BITS-1:0]),
      .dn_valid (cell_valid[0]),
      .dn_ready (cell_ready[0]),
      .dn_data  (cell_data[0])
   );

   // Chain of divider cells, one quotient bit each.
   for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
      dbl_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (cell_valid[i]),
         .up_ready (cell_ready[i]),
         .up_data  (cell_data[i]),
         .dn_valid (cell_valid[i+1]),
         .dn_ready (cell_ready[i+1]),
         .dn_data  (cell_data[i+1])
      );
   end

   // Result formatting and output register.
   dbl_out u_out (
      .clock          (clock),
      .reset          (reset),
      .up_valid       (cell_valid[QUO_BITS]),
      .up_ready       (cell_ready[QUO_BITS]),
      .up_data        (cell_data[QUO_BITS]),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .depth_fraction (rsp.depth_fraction),
      .gray_level     (rsp.gray_level),
      .was_clamped    (rsp.was_clamped)
   );

endmodule

>>> rtl/dbl_checker.sv
module dbl_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [dbl_pkg::FRAC_W-1:0]    depth_fraction,
   input logic [dbl_pkg::GRAY_BITS-1:0] gray_level,
   input logic                          was_clamped
);
   import dbl_pkg::*;

   logic [FRAC_W+GRAY_BITS-1:0] gray_prod;

   assign gray_prod = {depth_fraction, {GRAY_BITS{1'b0}}}
                      - (FRAC_W+GRAY_BITS)'(depth_fraction);

   // A stalled result holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(depth_fraction)
                                  && $stable(gray_level) && $stable(was_clamped))
      else $error("rsp payload changed while stalled");

   // The fraction never exceeds 1.0.
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> depth_fraction <= FRAC_ONE)
      else $error("depth_fraction above 1.0");

   // A clamped result sits at one of the two bounds.
   a_clamp_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && was_clamped |-> depth_fraction == '0 || depth_fraction == FRAC_ONE)
      else $error("clamped result not at a bound");

   // The gray level follows the fraction.
   a_gray_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> gray_level == gray_prod[QUO_BITS +: GRAY_BITS])
      else $error("gray_level does not match depth_fraction");

   // Nothing is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind depth_buffer_linearizer_top dbl_checker u_dbl_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .depth_fraction (rsp.depth_fraction),
   .gray_level     (rsp.gray_level),
   .was_clamped    (rsp.was_clamped)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import dbl_pkg::*;

   // Fraction bits of the coefficient registers in this build.
   localparam int FRAC_SHIFT = 24;

   localparam logic [COEFF_BITS-1:0] COEFF_ONE = COEFF_BITS'(1) << FRAC_SHIFT;
   localparam logic [COEFF_BITS-1:0] COEFF_MAX = '1;
   localparam logic [COEFF_BITS-1:0] MODE_PERSP = COEFF_BITS'(1);
   localparam logic [COEFF_BITS-1:0] MODE_ORTHO = COEFF_BITS'(0);

   // Index that selects no register; a write there must change nothing.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_TEXELS  = 106;
   localparam int IDLE_PERCENT  = 8;
   localparam int HOLD_CYCLES   = 150;
   localparam int CYCLE_LIMIT   = 200000;

   typedef struct packed {
      logic [FRAC_W-1:0]    fraction;
      logic [GRAY_BITS-1:0] gray;
      logic                 clamped;
   } depth_sample_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [COEFF_BITS-1:0] csr_wdata;

   dbl_req_if req_if();
   dbl_rsp_if rsp_if();

   // Camera setup as the block should currently hold it.
   logic                  cam_perspective;
   logic [COEFF_BITS-1:0] cam_scale;
   logic [COEFF_BITS-1:0] cam_offset;

   logic [TEXEL_BITS-1:0] texel_backlog[$];
   depth_sample_type      expected_depths[$];

   int idle_pct = IDLE_PERCENT;
   int mismatch_count = 0;
   int cycle_count = 0;
   int served = 0;
   int hold_left = 0;

   depth_buffer_linearizer_top #(.FRAC_BITS(FRAC_SHIFT)) uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Linear depth of one texel under the current camera setup, computed exactly
   // in integers: perspective is N*M / (D*M - raw*2^F), orthographic is
   // N*raw / (M*2^F), with M the largest 24-bit depth.
   function automatic depth_sample_type linearize_texel(logic [TEXEL_BITS-1:0] texel);
      logic [63:0] depth;
      logic [63:0] numer;
      logic [63:0] denom;
      logic [63:0] far_term;
      logic [63:0] near_term;
      logic [79:0] quotient;
      depth_sample_type s;
      depth = 64'(texel[DEPTH_BITS-1:0]);
      s = '0;
      if (cam_perspective) begin
         far_term  = 64'(cam_offset) * 64'(DEPTH_MAX);
         near_term = depth << FRAC_SHIFT;
         numer     = 64'(cam_scale) * 64'(DEPTH_MAX);
         // A negative divisor gives zero and a zero divisor saturates to one.
         if (far_term <= near_term) begin
            s.clamped = 1'b1;
            if (far_term == near_term) begin
               s.fraction = FRAC_ONE;
               s.gray     = '1;
            end
            return s;
         end
         denom = far_term - near_term;
      end else begin
         numer = 64'(cam_scale) * depth;
         denom = 64'(DEPTH_MAX) << FRAC_SHIFT;
      end
      // Exactly 1.0 is a legal result; only values beyond it count as clamped.
      if (numer >= denom) begin
         s.fraction = FRAC_ONE;
         s.clamped  = (numer > denom);
      end else begin
         quotient   = {numer, 16'h0000} / 80'(denom);
         s.fraction = FRAC_W'(quotient);
      end
      s.gray = GRAY_BITS'((32'(s.fraction) * 32'd255) >> QUO_BITS);
      return s;
   endfunction

   // One register write; the local copy follows once the write edge has passed.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [COEFF_BITS-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_PERSPECTIVE_MODE: cam_perspective = data[0];
         REG_SCALE_COEFF:      cam_scale = data;
         REG_OFFSET_COEFF:     cam_offset = data;
         default: begin
         end
      endcase
   endtask

   task automatic load_camera(input logic [COEFF_BITS-1:0] mode_word,
                              input logic [COEFF_BITS-1:0] scale,
                              input logic [COEFF_BITS-1:0] offset);
      write_csr(REG_PERSPECTIVE_MODE, mode_word);
      write_csr(REG_SCALE_COEFF, scale);
      write_csr(REG_OFFSET_COEFF, offset);
      @(negedge clock);
   endtask

   // Returns at a falling edge once nothing is queued, offered or outstanding.
   task automatic wait_idle();
      do @(negedge clock);
      while (texel_backlog.size() != 0 || req_if.valid || expected_depths.size() != 0);
   endtask

   // Texel driver: when free, offers the next queued texel unless it idles at random.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (texel_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_if.valid      <= 1'b1;
            req_if.texel_word <= texel_backlog.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result sink: random stalls, plus long hold-offs that fill the pipeline.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            served++;
            if (served == 40 || served == 700) begin
               hold_left = HOLD_CYCLES;
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   // Monitor: predict on each texel transfer, check on each result transfer.
   always @(posedge clock) begin
      depth_sample_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            expected_depths.push_back(linearize_texel(req_if.texel_word));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_depths.size() == 0) begin
               $display("%0t: result with no texel pending: fraction %0d gray %0d clamped %0d",
                        $time, rsp_if.depth_fraction, rsp_if.gray_level, rsp_if.was_clamped);
               mismatch_count++;
            end else begin
               want = expected_depths.pop_front();
               if (rsp_if.depth_fraction !== want.fraction) begin
                  $display("%0t: depth_fraction expected %0d actual %0d",
                           $time, want.fraction, rsp_if.depth_fraction);
                  mismatch_count++;
               end
               if (rsp_if.gray_level !== want.gray) begin
                  $display("%0t: gray_level expected %0d actual %0d",
                           $time, want.gray, rsp_if.gray_level);
                  mismatch_count++;
               end
               if (rsp_if.was_clamped !== want.clamped) begin
                  $display("%0t: was_clamped expected %0d actual %0d",
                           $time, want.clamped, rsp_if.was_clamped);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [COEFF_BITS-1:0] mode_word;
      logic [COEFF_BITS-1:0] scale;
      logic [COEFF_BITS-1:0] offset;
      logic [63:0]           knee;
      logic [DEPTH_BITS-1:0] depth;
      int                    pick;

      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = REG_PERSPECTIVE_MODE;
      csr_wdata         = '0;
      req_if.valid      = 1'b0;
      req_if.texel_word = '0;
      rsp_if.ready      = 1'b0;
      cam_perspective   = 1'b1;
      cam_scale         = COEFF_ONE;
      cam_offset        = COEFF_ONE;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset setup: the divisor is never above the numerator, so every texel
      // saturates; depth zero lands on exactly 1.0 and full depth hits a zero divisor.
      texel_backlog = '{32'h0000_0000, 32'h0000_0001, 32'h0080_0000,
                        32'h00FF_FFFF, 32'hFF00_0000, 32'hFFFF_FFFE};
      wait_idle();

      // Offset 0.5, scale 0.25: half-way value, small positive and negative divisors.
      load_camera(MODE_PERSP, COEFF_ONE >> 2, COEFF_ONE >> 1);
      texel_backlog = '{32'h0000_0000, 32'h007F_FFFF, 32'h0080_0000, 32'h00FF_FFFF};
      wait_idle();

      // Zero numerator: still saturates on a zero divisor, exact zero otherwise.
      load_camera(MODE_PERSP, '0, COEFF_ONE);
      texel_backlog = '{32'h00FF_FFFF, 32'h0000_0000, 32'h0012_3456};
      wait_idle();

      // Orthographic at unit scale, mode word with its upper bits set.
      load_camera(40'hFF_FFFF_FFFE, COEFF_ONE, COEFF_ONE);
      texel_backlog = '{32'h0000_0000, 32'h00FF_FFFF, 32'h007F_FFFF, 32'hAB80_0000};
      wait_idle();

      // Orthographic at the largest scale.
      load_camera(MODE_ORTHO, COEFF_MAX, COEFF_ONE);
      texel_backlog = '{32'h0000_0000, 32'h0000_0100, 32'h00FF_FFFF};
      wait_idle();

      // A write to the spare index must leave the setup alone.
      write_csr(REG_UNUSED, {8'($urandom), 32'($urandom)});
      load_camera(MODE_PERSP, COEFF_MAX, COEFF_MAX);
      write_csr(REG_UNUSED, '1);
      @(negedge clock);
      texel_backlog = '{32'h00FF_FFFF, 32'h0000_0000};
      wait_idle();

      // Random phases, each with its own camera setup.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         mode_word = {8'($urandom), 32'($urandom)};
         scale     = COEFF_ONE;
         offset    = COEFF_ONE;
         case (p)
            0, 7, 11: begin
               // Realistic perspective: D >= 1.0, N near D - 1.0.
               mode_word[0] = 1'b1;
               offset = COEFF_ONE + COEFF_BITS'($urandom_range(0, 32'h0400_0000));
               scale  = COEFF_BITS'(((64'(offset) - 64'(COEFF_ONE))
                                     * $urandom_range(0, 1100)) / 1000);
            end
            1, 10: begin
               mode_word[0] = 1'b0;
               scale  = COEFF_BITS'($urandom_range(32'h0080_0000, 32'h0200_0000));
               offset = {8'($urandom), 32'($urandom)};
            end
            2: begin
               mode_word[0] = 1'b1;
               scale  = {8'($urandom), 32'($urandom)} >> $urandom_range(8, 20);
               offset = COEFF_BITS'($urandom_range(0, 32'h0200_0000));
            end
            3: begin
               mode_word[0] = 1'b0;
               scale  = {8'($urandom), 32'($urandom)} >> $urandom_range(14, 18);
            end
            4: begin
               mode_word[0] = 1'b1;
               scale  = {8'($urandom), 32'($urandom)} >> 16;
               offset = '0;
            end
            5: begin
               mode_word[0] = 1'b0;
               scale  = COEFF_MAX;
            end
            6: begin
               mode_word[0] = 1'b1;
               scale  = COEFF_MAX;
               offset = COEFF_MAX;
            end
            8: begin
               mode_word[0] = 1'b0;
               scale  = '0;
               offset = {8'($urandom), 32'($urandom)};
            end
            default: begin
               mode_word[0] = 1'b1;
               scale  = {8'($urandom), 32'($urandom)};
               offset = {8'($urandom), 32'($urandom)};
            end
         endcase
         load_camera(mode_word, scale, offset);
         // One phase runs with no idling on either side.
         idle_pct = (p == 7) ? 0 : IDLE_PERCENT;

         for (int i = 0; i < PHASE_TEXELS; i++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
               depth = DEPTH_BITS'($urandom);
            end else if (pick < 65) begin
               depth = DEPTH_MAX - DEPTH_BITS'($urandom_range(0, 65535));
            end else if (pick < 75) begin
               depth = DEPTH_BITS'($urandom_range(0, 255));
            end else begin
               // Close to where the result crosses 1.0 or the divisor crosses zero.
               if (cam_perspective) begin
                  knee = (64'(cam_offset) * 64'(DEPTH_MAX)) >> FRAC_SHIFT;
               end else if (cam_scale != 0) begin
                  knee = (64'(DEPTH_MAX) << FRAC_SHIFT) / 64'(cam_scale);
               end else begin
                  knee = 64'(DEPTH_MAX);
               end
               knee = knee + 64'($urandom_range(0, 4));
               knee = (knee < 2) ? 64'($urandom_range(0, 2)) : knee - 2;
               if (knee > 64'(DEPTH_MAX)) begin
                  knee = 64'(DEPTH_MAX);
               end
               depth = DEPTH_BITS'(knee);
            end
            texel_backlog.push_back({8'($urandom), depth});
         end
         wait_idle();
      end

      repeat (25) @(posedge clock);
      if (mismatch_count == 0 && expected_depths.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/dbl_pkg.sv
rtl/dbl_req_if.sv
rtl/dbl_rsp_if.sv
rtl/dbl_prep.sv
rtl/dbl_div_cell.sv
rtl/dbl_out.sv
rtl/depth_buffer_linearizer_top.sv
rtl/dbl_checker.sv
tb/testbench.sv
